/* rtl/tcfe_pkg.sv */
package tcfe_pkg;

  localparam int unsigned DayQuotW = 18;
  localparam int unsigned DayDivW  = 49;
  localparam logic [63:0] DayDivisorHi = 64'd1318359375;
  localparam logic [64:0] BiasNs = 65'd9223372800000000000;
  localparam int unsigned RemHiW = 31;

  localparam int unsigned SodW    = 17;
  localparam int unsigned SecDivW = 38;
  localparam logic [63:0] SecDivisorHi = 64'd1953125;
  localparam int unsigned SecRemW = 21;

  localparam logic [19:0] ZOffset   = 20'd612716;
  localparam logic [19:0] EraStart4 = 20'd584388;
  localparam logic [19:0] EraStart5 = 20'd730485;

  localparam logic [17:0] CentLen1 = 18'd36524;
  localparam logic [17:0] CentLen2 = 18'd73048;
  localparam logic [17:0] CentLen3 = 18'd109572;
  localparam logic [17:0] CentLen4 = 18'd146096;

  localparam longint unsigned Recip1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam longint unsigned Recip365  = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam longint unsigned RecipSec60 = ((64'd1 << 23) + 64'd59) / 64'd60;
  localparam longint unsigned RecipMin60 = ((64'd1 << 17) + 64'd59) / 64'd60;

  typedef enum logic [2:0] {
    FieldYear   = 3'd0,
    FieldMonth  = 3'd1,
    FieldDay    = 3'd2,
    FieldHour   = 3'd3,
    FieldMinute = 3'd4,
    FieldSecond = 3'd5
  } field_sel_e;

  typedef struct packed {
    logic signed [63:0] timestamp_ns;
    logic               is_null;
  } in_word_t;

  typedef struct packed {
    logic [11:0] field_value;
    logic [29:0] fraction_ns;
    logic        result_null;
  } out_word_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic        is_null;
    logic [15:0] low;
  } day_side_t;

  typedef struct packed {
    logic              is_null;
    logic [RemHiW-1:0] rem_hi;
    logic [15:0]       low;
  } date_side_t;

  typedef struct packed {
    logic       is_null;
    date_t      date;
    logic [8:0] low;
  } sec_side_t;

  typedef struct packed {
    logic        is_null;
    date_t       date;
    logic [29:0] frac;
  } tm_side_t;

  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/tcfe_restore_div.sv */
module tcfe_restore_div #(
  parameter int unsigned DividendW = 49,
  parameter int unsigned QuotW     = 18,
  parameter logic [63:0] Divisor   = 64'd1318359375,
  parameter int unsigned SideW     = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 vld_o,
  output logic [QuotW-1:0]     quot_o,
  output logic [DividendW-1:0] rem_o,
  output logic [SideW-1:0]     side_o
);

  localparam int unsigned HiW    = 32;
  localparam int unsigned ProdW  = 2 * HiW;
  localparam int unsigned Shift  = DividendW - HiW;
  localparam int unsigned Stages = 4;

  localparam logic [HiW-1:0]       Recip = HiW'((64'd1 << DividendW) / Divisor);
  localparam logic [DividendW-1:0] Div1  = DividendW'(Divisor);
  localparam logic [DividendW-1:0] Div2  = DividendW'(Divisor << 1);

  logic             vld_q  [Stages];
  logic [SideW-1:0] side_q [Stages];

  logic [ProdW-1:0]     prod_hi_q;
  logic [DividendW-1:0] num1_q, num2_q;
  logic [QuotW-1:0]     q2_q, q3_q, quot_q;
  logic [DividendW-1:0] back_q;
  logic [DividendW-1:0] r3_q, rem_q;

  logic [QuotW-1:0]     q_est;
  logic [QuotW-1:0]     quot_d;
  logic [DividendW-1:0] rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < Stages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < Stages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // The estimate from the top bits falls short of the true quotient by at
  // most two, which the last stage makes up.
  assign q_est = QuotW'(prod_hi_q[ProdW-1:HiW]);

  always_comb begin
    if (r3_q >= Div2) begin
      quot_d = q3_q + QuotW'(2);
      rem_d  = r3_q - Div2;
    end else if (r3_q >= Div1) begin
      quot_d = q3_q + QuotW'(1);
      rem_d  = r3_q - Div1;
    end else begin
      quot_d = q3_q;
      rem_d  = r3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_hi_q <= ProdW'(dividend_i[DividendW-1:Shift]) * ProdW'(Recip);
      num1_q    <= dividend_i;

      q2_q      <= q_est;
      back_q    <= DividendW'(q_est) * Div1;
      num2_q    <= num1_q;

      r3_q      <= num2_q - back_q;
      q3_q      <= q2_q;

      quot_q    <= quot_d;
      rem_q     <= rem_d;
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign side_o = side_q[Stages-1];

endmodule

/* rtl/tcfe_civil_date.sv */
module tcfe_civil_date import tcfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [DayQuotW-1:0] days_i,
  input  date_side_t          side_i,
  output logic                vld_o,
  output date_t               date_o,
  output date_side_t          side_o
);

  localparam int unsigned Stages = 9;

  logic       vld_q  [Stages];
  date_side_t side_q [Stages];

  logic [19:0] z_q;
  logic        hi1_q, hi2_q, hi3_q, hi4_q, hi5_q, hi6_q, hi7_q;
  logic [17:0] doe_q, doe2_q, doe3_q, doe4_q, doe5_q;
  logic [36:0] p1_q;
  logic [2:0]  c4_q;
  logic        c1_q;
  logic [17:0] n_q;
  logic [36:0] p2_q;
  logic [8:0]  yoe_q, yoe6_q, yoe7_q;
  logic [8:0]  doy_q, doy7_q;
  logic [3:0]  mp_q;
  date_t       date_q;

  logic [17:0] doe_d;
  logic [2:0]  c4_d;
  logic [17:0] n_d;
  logic [1:0]  c100;
  logic [17:0] doy_full;
  logic [3:0]  mp_d;
  logic [8:0]  day_full;
  date_t       date_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < Stages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < Stages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign doe_d = (z_q >= EraStart5) ? 18'(z_q - EraStart5) : 18'(z_q - EraStart4);

  assign c4_d = 3'(doe_q >= CentLen1) + 3'(doe_q >= CentLen2)
              + 3'(doe_q >= CentLen3) + 3'(doe_q >= CentLen4);

  assign n_d = doe2_q - 18'(p1_q[35:29]) + 18'(c4_q) - 18'(c1_q);

  assign c100 = 2'(yoe_q >= 9'd100) + 2'(yoe_q >= 9'd200) + 2'(yoe_q >= 9'd300);
  assign doy_full = doe5_q
                  - (18'(yoe_q) * 18'd365 + 18'(yoe_q[8:2]) - 18'(c100));

  always_comb begin
    mp_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy_q >= month_start(4'(k))) begin
        mp_d = mp_d + 4'd1;
      end
    end
  end

  always_comb begin
    day_full     = doy7_q - month_start(mp_q) + 9'd1;
    date_d.day   = day_full[4:0];
    date_d.month = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
    date_d.year  = 12'(yoe7_q) + (hi7_q ? 12'd2000 : 12'd1600) + 12'(mp_q >= 4'd10);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q    <= 20'(days_i) + ZOffset;

      hi1_q  <= z_q >= EraStart5;
      doe_q  <= doe_d;

      p1_q   <= 37'(doe_q) * 37'(Recip1460);
      c4_q   <= c4_d;
      c1_q   <= doe_q == CentLen4;
      doe2_q <= doe_q;
      hi2_q  <= hi1_q;

      n_q    <= n_d;
      doe3_q <= doe2_q;
      hi3_q  <= hi2_q;

      p2_q   <= 37'(n_q) * 37'(Recip365);
      doe4_q <= doe3_q;
      hi4_q  <= hi3_q;

      yoe_q  <= p2_q[35:27];
      doe5_q <= doe4_q;
      hi5_q  <= hi4_q;

      doy_q  <= doy_full[8:0];
      yoe6_q <= yoe_q;
      hi6_q  <= hi5_q;

      mp_q   <= mp_d;
      doy7_q <= doy_q;
      yoe7_q <= yoe6_q;
      hi7_q  <= hi6_q;

      date_q <= date_d;
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign date_o = date_q;
  assign side_o = side_q[Stages-1];

endmodule

/* rtl/tcfe_time_split.sv */
module tcfe_time_split import tcfe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [SodW-1:0] sod_i,
  input  tm_side_t        side_i,
  output logic            vld_o,
  output hms_t            hms_o,
  output tm_side_t        side_o
);

  localparam int unsigned Stages = 3;

  logic     vld_q  [Stages];
  tm_side_t side_q [Stages];

  logic [34:0]     p_q;
  logic [SodW-1:0] sod_q;
  logic [10:0]     mt_q;
  logic [5:0]      sec_q;
  logic [22:0]     ph_q;
  hms_t            hms_q;

  logic [10:0]     mt;
  logic [SodW-1:0] sec_full;
  logic [4:0]      hr;
  logic [10:0]     min_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < Stages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < Stages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign mt       = p_q[33:23];
  assign sec_full = sod_q - SodW'(mt) * SodW'(60);
  assign hr       = ph_q[21:17];
  assign min_full = mt_q - 11'(hr) * 11'd60;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q          <= 35'(sod_i) * 35'(RecipSec60);
      sod_q        <= sod_i;

      mt_q         <= mt;
      sec_q        <= sec_full[5:0];
      ph_q         <= 23'(mt) * 23'(RecipMin60);

      hms_q.hour   <= hr;
      hms_q.minute <= min_full[5:0];
      hms_q.second <= sec_q;
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign hms_o  = hms_q;
  assign side_o = side_q[Stages-1];

endmodule

/* rtl/timestamp_civil_field_extract_unit.sv */
// Calendar field extraction from signed 64-bit nanosecond UNIX timestamps.
// The input channel (in_valid_i, in_ready_o, in_data_i) takes one timestamp
// word with its null flag; the output channel (out_valid_o, out_ready_i,
// out_data_o) returns one result word per input word, in order.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
// field select: year, month, day, hour, minute or second; other codes give null.
// It is always ready and should only be written while no words are in flight.
// The pipeline is the input register, the two dividers by a constant,
// four stages each (reciprocal estimate, multiply back, remainder, final
// adjust), the 9-stage date conversion, the 3-stage time split and the
// output register. A new word is accepted in every cycle while the receiver
// does not stall. When the receiver stalls, the whole pipeline holds and
// in_ready_o drops until the output register is emptied; nothing is lost
// or repeated.
// Reset clears every valid bit and selects the year field.
module timestamp_civil_field_extract_unit import tcfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic        en;
  logic [2:0]  field_select_q;

  logic        s0_vld_q;
  logic [64:0] u_q;
  logic        s0_null_q;

  day_side_t            day_side_in, day_side_out;
  logic                 day_vld;
  logic [DayQuotW-1:0]  day_quot;
  logic [DayDivW-1:0]   day_rem;

  date_side_t           date_side_in, date_side_out;
  logic                 date_vld;
  date_t                date;

  sec_side_t            sec_side_in, sec_side_out;
  logic [SecDivW-1:0]   sec_dividend;
  logic                 sec_vld;
  logic [SodW-1:0]      sod;
  logic [SecDivW-1:0]   sec_rem;

  tm_side_t             tm_side_in, tm_side_out;
  logic                 tm_vld;
  hms_t                 hms;

  logic                 out_valid_q;
  out_word_t            out_data_q;
  out_word_t            out_data_d;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_select_q <= FieldYear;
    end else if (cfg_valid_i && cfg_ready_o) begin
      field_select_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  // The bias is a whole number of days, so floor division becomes unsigned.
  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q       <= {in_data_i.timestamp_ns[63], in_data_i.timestamp_ns} + BiasNs;
      s0_null_q <= in_data_i.is_null;
    end
  end

  assign day_side_in.is_null = s0_null_q;
  assign day_side_in.low     = u_q[15:0];

  tcfe_restore_div #(
    .DividendW (DayDivW),
    .QuotW     (DayQuotW),
    .Divisor   (DayDivisorHi),
    .SideW     ($bits(day_side_t))
  ) u_day_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (s0_vld_q),
    .dividend_i (u_q[64:16]),
    .side_i     (day_side_in),
    .vld_o      (day_vld),
    .quot_o     (day_quot),
    .rem_o      (day_rem),
    .side_o     (day_side_out)
  );

  assign date_side_in.is_null = day_side_out.is_null;
  assign date_side_in.rem_hi  = day_rem[RemHiW-1:0];
  assign date_side_in.low     = day_side_out.low;

  tcfe_civil_date u_civil_date (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (day_vld),
    .days_i (day_quot),
    .side_i (date_side_in),
    .vld_o  (date_vld),
    .date_o (date),
    .side_o (date_side_out)
  );

  assign sec_dividend        = {date_side_out.rem_hi, date_side_out.low[15:9]};
  assign sec_side_in.is_null = date_side_out.is_null;
  assign sec_side_in.date    = date;
  assign sec_side_in.low     = date_side_out.low[8:0];

  tcfe_restore_div #(
    .DividendW (SecDivW),
    .QuotW     (SodW),
    .Divisor   (SecDivisorHi),
    .SideW     ($bits(sec_side_t))
  ) u_sec_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (date_vld),
    .dividend_i (sec_dividend),
    .side_i     (sec_side_in),
    .vld_o      (sec_vld),
    .quot_o     (sod),
    .rem_o      (sec_rem),
    .side_o     (sec_side_out)
  );

  assign tm_side_in.is_null = sec_side_out.is_null;
  assign tm_side_in.date    = sec_side_out.date;
  assign tm_side_in.frac    = {sec_rem[SecRemW-1:0], sec_side_out.low};

  tcfe_time_split u_time_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sec_vld),
    .sod_i  (sod),
    .side_i (tm_side_in),
    .vld_o  (tm_vld),
    .hms_o  (hms),
    .side_o (tm_side_out)
  );

  always_comb begin
    out_data_d = '0;
    unique case (field_select_q)
      FieldYear:   out_data_d.field_value = tm_side_out.date.year;
      FieldMonth:  out_data_d.field_value = 12'(tm_side_out.date.month);
      FieldDay:    out_data_d.field_value = 12'(tm_side_out.date.day);
      FieldHour:   out_data_d.field_value = 12'(hms.hour);
      FieldMinute: out_data_d.field_value = 12'(hms.minute);
      FieldSecond: begin
        out_data_d.field_value = 12'(hms.second);
        out_data_d.fraction_ns = tm_side_out.frac;
      end
      default:     out_data_d.result_null = 1'b1;
    endcase
    if (tm_side_out.is_null) begin
      out_data_d = '0;
      out_data_d.result_null = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tm_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/tcfe_checker.sv */
module tcfe_checker import tcfe_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // A stalled result word must hold until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The block may only refuse input while a result word is waiting.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input refused with free output register");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.result_null |->
      out_data_o.field_value <= 12'd2262 && out_data_o.fraction_ns < 30'd1000000000)
    else $error("result field out of range");

  a_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_null |->
      out_data_o.field_value == 12'd0 && out_data_o.fraction_ns == 30'd0)
    else $error("null result carries a value");

endmodule

bind timestamp_civil_field_extract_unit tcfe_checker u_tcfe_checker (.*);

/* tb/tb_timestamp_civil_field_extract_unit.sv */
`timescale 1ns / 1ps
module tb_timestamp_civil_field_extract_unit;
  import tcfe_pkg::*;

  localparam longint NsPerSec  = 64'sd1000000000;
  localparam longint NsPerMin  = 60 * NsPerSec;
  localparam longint NsPerHour = 60 * NsPerMin;
  localparam longint NsPerDay  = 24 * NsPerHour;

  localparam int CycleLimit    = 400000;
  localparam int RandPhases    = 16;
  localparam int WordsPerPhase = 106;
  localparam int DrainCycles   = 60;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_word_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_word_t  out_data_o;

  in_word_t   ts_backlog[$];
  out_word_t  due_fields[$];
  out_word_t  want_word;
  logic [2:0] sel_model = FieldYear;

  bit calm_tail      = 1'b0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int n_cycles       = 0;
  int n_errors       = 0;
  int n_accepted     = 0;
  int n_checked      = 0;
  int n_cfg_writes   = 0;

  longint corner_stamps [12] = '{
    64'sh8000000000000000,
    64'sh7FFFFFFFFFFFFFFF,
    64'sd0,
    -64'sd1,
    NsPerDay - 1,
    -NsPerDay,
    64'sd951782400 * NsPerSec + NsPerDay - 1,
    64'sd946684800 * NsPerSec - 1,
    -64'sd2203891200 * NsPerSec - 1,
    64'sd4107542400 * NsPerSec - 1,
    64'sd1,
    59 * NsPerSec + 64'sd999999999
  };

  timestamp_civil_field_extract_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_word_t civil_field_of(in_word_t w, logic [2:0] sel);
    out_word_t r;
    longint t, days, rem, z, era, doe, yoe, doy, mp, d, m, y, val, frac;
    r = '0;
    if (w.is_null || sel > FieldSecond) begin
      r.result_null = 1'b1;
      return r;
    end
    t = w.timestamp_ns;
    days = t / NsPerDay;
    rem = t % NsPerDay;
    if (rem < 0) begin
      rem = rem + NsPerDay;
      days = days - 1;
    end
    // Eras of 400 years counted from 0000-03-01.
    z = days + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? mp + 3 : mp - 9;
    y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    frac = 0;
    case (sel)
      FieldYear:   val = y;
      FieldMonth:  val = m;
      FieldDay:    val = d;
      FieldHour:   val = rem / NsPerHour;
      FieldMinute: val = (rem % NsPerHour) / NsPerMin;
      FieldSecond: begin
        val = (rem % NsPerMin) / NsPerSec;
        frac = rem % NsPerSec;
      end
      default:     val = 0;
    endcase
    r.field_value = val[11:0];
    r.fraction_ns = frac[29:0];
    r.result_null = 1'b0;
    return r;
  endfunction

  task automatic write_field_select(input logic [2:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sel_model = v;
    n_cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (ts_backlog.size() != 0 || in_valid_i || due_fields.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_fields.push_back(civil_field_of(in_data_i, sel_model));
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!calm_tail && ts_backlog.size() != 0 &&
                     $urandom_range(0, 99) < send_gap_pct) begin
          gap_left = $urandom_range(1, 16) - 1;
          in_valid_i <= 1'b0;
        end else if (ts_backlog.size() != 0) begin
          in_data_i  <= ts_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_fields.size() == 0) begin
          $error("result word arrived with no timestamp outstanding");
          n_errors++;
        end else begin
          want_word = due_fields.pop_front();
          n_checked++;
          if (out_data_o.field_value !== want_word.field_value) begin
            $error("field_value: expected %0d, actual %0d",
                   want_word.field_value, out_data_o.field_value);
            n_errors++;
          end
          if (out_data_o.fraction_ns !== want_word.fraction_ns) begin
            $error("fraction_ns: expected %0d, actual %0d",
                   want_word.fraction_ns, out_data_o.fraction_ns);
            n_errors++;
          end
          if (out_data_o.result_null !== want_word.result_null) begin
            $error("result_null: expected %0d, actual %0d",
                   want_word.result_null, out_data_o.result_null);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < recv_stall_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_word_t        w;
    logic [2:0]      sel;
    longint          ts, day_no, tod;
    longint unsigned u;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gap_pct   = 30;
    recv_stall_pct = 30;

    // The first group runs on the reset value of the field select.
    for (int s = 0; s < 8; s++) begin
      if (s != 0) write_field_select(3'(s));
      for (int k = 0; k < 3; k++) begin
        w.timestamp_ns = corner_stamps[(3 * s + k) % 12];
        w.is_null      = (k == 2) && (s % 2 == 1);
        ts_backlog.push_back(w);
      end
      wait_until_drained();
    end

    for (int p = 0; p < RandPhases; p++) begin
      if (p < 8) sel = 3'(p);
      else if ($urandom_range(0, 3) == 0) sel = 3'($urandom_range(0, 7));
      else sel = 3'($urandom_range(0, 5));
      calm_tail = (p >= RandPhases - 2);
      case ($urandom_range(0, 2))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 10;
        default: send_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_stall_pct = 0;
        1:       recv_stall_pct = 10;
        default: recv_stall_pct = 40;
      endcase
      write_field_select(sel);
      for (int n = 0; n < WordsPerPhase; n++) begin
        case ($urandom_range(0, 5))
          0: ts = {$urandom, $urandom};
          1: ts = $urandom_range(0, 1) ?
                  (64'sh8000000000000000 + longint'($urandom)) :
                  (64'sh7FFFFFFFFFFFFFFF - longint'($urandom));
          2: ts = longint'(int'($urandom));
          default: begin
            day_no = longint'($urandom_range(0, 213501)) - 106751;
            case ($urandom_range(0, 2))
              0: begin
                u = {$urandom, $urandom};
                tod = longint'(u % NsPerDay);
              end
              1: tod = $urandom_range(0, 1) ?
                       (NsPerDay - 1 - longint'($urandom_range(0, 999))) :
                       longint'($urandom_range(0, 999));
              default: tod = longint'($urandom_range(0, 23)) * NsPerHour +
                             longint'($urandom_range(0, 59)) * NsPerMin +
                             longint'($urandom_range(0, 59)) * NsPerSec +
                             ($urandom_range(0, 1) ? 64'sd999999999 :
                              longint'($urandom_range(0, 999999999)));
            endcase
            ts = day_no * NsPerDay + tod;
          end
        endcase
        w.timestamp_ns = ts;
        w.is_null      = ($urandom_range(0, 9) == 0);
        ts_backlog.push_back(w);
      end
      wait_until_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Converted %0d timestamp words under %0d field-select writes, all selector codes.",
             n_accepted, n_cfg_writes);
    $display("Checked %0d result words, %0d mismatches found.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
